FILE: hdl/hcho_frx_pkg.sv
package hcho_frx_pkg;

    // frame layout
    localparam logic [3:0] FRAME_LEN   = 4'd10;
    localparam logic [3:0] SUM_END     = 4'd8;   // bytes below this offset are summed
    localparam logic [3:0] BODY_FIRST  = 4'd2;   // first byte kept for the checks
    localparam logic [3:0] BODY_LAST   = 4'd8;   // last byte kept (byte 9 arrives live)
    localparam int         BODY_LEN    = 7;
    localparam int         BODY_IDX_W  = 3;

    localparam logic [7:0] HDR_FIRST   = 8'h42;
    localparam logic [7:0] HDR_SECOND  = 8'h4D;
    localparam logic [7:0] RESP_CMD    = 8'h08;

    // configuration registers
    localparam logic CFG_GAS_TYPE = 1'b0;
    localparam logic CFG_UNIT     = 1'b1;

    localparam logic [7:0] GAS_TYPE_RST = 8'h14;
    localparam logic [7:0] UNIT_RST     = 8'h05;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_INCOMPLETE = 3'd1;
    localparam logic [2:0] ST_BAD_CMD    = 3'd2;
    localparam logic [2:0] ST_BAD_TYPE   = 3'd3;
    localparam logic [2:0] ST_BAD_SUM    = 3'd4;
    localparam logic [2:0] ST_BAD_SCALE  = 3'd5;

    localparam int CONC_W = 26;

    // one finished assembly handed to the checks
    typedef struct packed {
        logic        timeout;
        logic [3:0]  count;
        logic [7:0]  cmd;
        logic [7:0]  gas_type;
        logic [7:0]  unit;
        logic [7:0]  scale_code;
        logic [15:0] raw;
        logic [15:0] sent_sum;
        logic [15:0] calc_sum;
    } frame_rec_t;

    // ug/m3 multiplier per scale code, zero for a code that means nothing
    function automatic logic [9:0] scale_factor(input logic [7:0] code);
        logic [9:0] f;
        case (code)
            8'd1:    f = 10'd1000;
            8'd2:    f = 10'd100;
            8'd3:    f = 10'd10;
            8'd4:    f = 10'd1;
            default: f = 10'd0;
        endcase
        return f;
    endfunction

endpackage

FILE: hdl/hcho_frx_assembler.sv
module hcho_frx_assembler
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    action,
    input  logic [7:0]              rx_byte,
    output logic                    rec_valid,
    input  logic                    rec_ready,
    output hcho_frx_pkg::frame_rec_t rec
);

    logic [3:0]  count_reg, count_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  body_reg [hcho_frx_pkg::BODY_LEN];
    logic        rec_valid_reg, rec_valid_next;
    hcho_frx_pkg::frame_rec_t rec_reg, rec_next;

    logic                                accept;
    logic                                store_en;
    logic                                emit;
    logic [hcho_frx_pkg::BODY_IDX_W-1:0] body_idx;
    logic [3:0]                          body_off;

    assign in_ready = !rec_valid_reg || rec_ready;
    assign accept   = in_valid && in_ready;
    assign body_off = count_reg - hcho_frx_pkg::BODY_FIRST;
    assign body_idx = body_off[hcho_frx_pkg::BODY_IDX_W-1:0];

    // header hunt, count, running sum, body capture, timeout and record build
    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        store_en   = 1'b0;
        emit       = 1'b0;
        rec_next   = rec_reg;
        if (accept)
        begin
            if (action)
            begin
                emit             = 1'b1;
                rec_next.timeout = 1'b1;
                rec_next.count   = count_reg;
                count_next       = '0;
                sum_next         = '0;
            end
            else if (count_reg == 4'd0)
            begin
                if (rx_byte == hcho_frx_pkg::HDR_FIRST)
                begin
                    count_next = 4'd1;
                    sum_next   = {8'd0, rx_byte};
                end
            end
            else if (count_reg == 4'd1 && rx_byte != hcho_frx_pkg::HDR_SECOND)
            begin
                // another first header byte restarts the frame at one byte
                if (rx_byte == hcho_frx_pkg::HDR_FIRST)
                begin
                    sum_next = {8'd0, rx_byte};
                end
                else
                begin
                    count_next = '0;
                    sum_next   = '0;
                end
            end
            else if (count_reg >= hcho_frx_pkg::FRAME_LEN)
            begin
                count_next = '0;
                sum_next   = '0;
            end
            else
            begin
                store_en = (count_reg >= hcho_frx_pkg::BODY_FIRST)
                        && (count_reg <= hcho_frx_pkg::BODY_LAST);
                if (count_reg < hcho_frx_pkg::SUM_END)
                begin
                    sum_next = sum_reg + {8'd0, rx_byte};
                end
                count_next = count_reg + 4'd1;
                if (count_reg == hcho_frx_pkg::FRAME_LEN - 4'd1)
                begin
                    emit                = 1'b1;
                    rec_next.timeout    = 1'b0;
                    rec_next.count      = hcho_frx_pkg::FRAME_LEN;
                    rec_next.cmd        = body_reg[0];
                    rec_next.gas_type   = body_reg[1];
                    rec_next.unit       = body_reg[2];
                    rec_next.scale_code = body_reg[3];
                    rec_next.raw        = {body_reg[4], body_reg[5]};
                    rec_next.sent_sum   = {body_reg[6], rx_byte};
                    rec_next.calc_sum   = sum_reg;
                    count_next          = '0;
                    sum_next            = '0;
                end
            end
        end
    end

    always_comb
    begin
        if (emit)
        begin
            rec_valid_next = 1'b1;
        end
        else if (rec_ready)
        begin
            rec_valid_next = 1'b0;
        end
        else
        begin
            rec_valid_next = rec_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_reg       <= '0;
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            rec_valid_reg <= rec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
        if (store_en)
        begin
            body_reg[body_idx] <= rx_byte;
        end
    end

    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

endmodule

FILE: hdl/hcho_frx_validator.sv
module hcho_frx_validator
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rec_valid,
    output logic                              rec_ready,
    input  hcho_frx_pkg::frame_rec_t          rec,
    input  logic [7:0]                        exp_gas_type,
    input  logic [7:0]                        exp_unit,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [2:0]                        status,
    output logic [hcho_frx_pkg::CONC_W-1:0]   concentration_ug,
    output logic [3:0]                        bytes_collected
);

    logic                              out_valid_reg, out_valid_next;
    logic [2:0]                        status_reg, status_next;
    logic [hcho_frx_pkg::CONC_W-1:0]   conc_reg, conc_next;
    logic [3:0]                        count_reg;
    logic [9:0]                        factor;
    logic                              load;

    assign rec_ready = !out_valid_reg || out_ready;
    assign load      = rec_valid && rec_ready;
    assign factor    = hcho_frx_pkg::scale_factor(rec.scale_code);

    // checks in priority order
    always_comb
    begin
        conc_next = '0;
        if (rec.timeout)
        begin
            status_next = hcho_frx_pkg::ST_INCOMPLETE;
        end
        else if (rec.cmd != hcho_frx_pkg::RESP_CMD)
        begin
            status_next = hcho_frx_pkg::ST_BAD_CMD;
        end
        else if (rec.gas_type != exp_gas_type || rec.unit != exp_unit)
        begin
            status_next = hcho_frx_pkg::ST_BAD_TYPE;
        end
        else if (rec.sent_sum != rec.calc_sum)
        begin
            status_next = hcho_frx_pkg::ST_BAD_SUM;
        end
        else if (factor == 10'd0)
        begin
            status_next = hcho_frx_pkg::ST_BAD_SCALE;
        end
        else
        begin
            status_next = hcho_frx_pkg::ST_OK;
            conc_next   = hcho_frx_pkg::CONC_W'(rec.raw) * hcho_frx_pkg::CONC_W'(factor);
        end
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= status_next;
            conc_reg   <= conc_next;
            count_reg  <= rec.count;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign concentration_ug = conc_reg;
    assign bytes_collected  = count_reg;

endmodule

FILE: hdl/hcho_sensor_frame_receiver_unit.sv
// Formaldehyde sensor frame receiver. Each input beat is one received serial
// byte (action 0) or a timeout/abort (action 1). The block hunts for the
// header 0x42 0x4D, collects a 10-byte frame and, on the tenth byte, returns
// one result beat: a status (ok, bad command, bad gas type or unit, bad
// checksum, bad scale code) and, when ok, the concentration in ug/m3 as the
// raw word times 1000/100/10/1 for scale codes 1..4. A timeout always returns
// status incomplete with the number of frame bytes held, even zero, and
// clears the assembly. Bytes that do not complete a frame return nothing.
// Rate: one beat per clock while in_ready is high. The header hunt, byte count
// and 16-bit running sum update in the same cycle a byte is taken; a completed
// frame or timeout is latched into a record register, then checked and scaled
// (one 16x10 multiply) into the output register. Input stalls only while both
// the record and output registers are full and out_ready is low. Configuration
// writes (index 0: expected gas type, reset 0x14; index 1: expected unit,
// reset 0x05) take effect at once and belong in idle periods only.
module hcho_sensor_frame_receiver_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    // input beats
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [7:0]  rx_byte,
    // result beats
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [25:0] concentration_ug,
    output logic [3:0]  bytes_collected
);

    logic [7:0] gas_type_reg, gas_type_next;
    logic [7:0] unit_reg, unit_next;

    // handoff between byte assembly and frame checks
    logic                     rec_valid;
    logic                     rec_ready;
    hcho_frx_pkg::frame_rec_t rec;

    // register decode
    always_comb
    begin
        gas_type_next = gas_type_reg;
        unit_next     = unit_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                hcho_frx_pkg::CFG_GAS_TYPE: gas_type_next = cfg_data;
                hcho_frx_pkg::CFG_UNIT:     unit_next     = cfg_data;
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gas_type_reg <= hcho_frx_pkg::GAS_TYPE_RST;
            unit_reg     <= hcho_frx_pkg::UNIT_RST;
        end
        else
        begin
            gas_type_reg <= gas_type_next;
            unit_reg     <= unit_next;
        end
    end

    // header hunt, byte count, running sum, frame body capture
    hcho_frx_assembler u_asm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .rx_byte   (rx_byte),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec)
    );

    // command/type/unit/checksum/scale checks and output register
    hcho_frx_validator u_val
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .rec_valid        (rec_valid),
        .rec_ready        (rec_ready),
        .rec              (rec),
        .exp_gas_type     (gas_type_reg),
        .exp_unit         (unit_reg),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .concentration_ug (concentration_ug),
        .bytes_collected  (bytes_collected)
    );

endmodule

FILE: hdl/hcho_frx_props.sv
module hcho_frx_props
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [25:0] concentration_ug,
    input logic [3:0]  bytes_collected
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(concentration_ug) && $stable(bytes_collected))
        else $error("result beat changed while stalled");

    // only a completed frame can pass
    a_ok_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == hcho_frx_pkg::ST_OK |-> bytes_collected == hcho_frx_pkg::FRAME_LEN)
        else $error("ok status on a short frame");

    // failed frames carry no concentration
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != hcho_frx_pkg::ST_OK |-> concentration_ug == 26'd0)
        else $error("concentration on a failed result");

    // a timeout never reports a full frame
    a_tmo_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == hcho_frx_pkg::ST_INCOMPLETE |-> bytes_collected < hcho_frx_pkg::FRAME_LEN)
        else $error("incomplete status with a full count");

    // checked frames always report ten bytes
    a_chk_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != hcho_frx_pkg::ST_INCOMPLETE |-> bytes_collected == hcho_frx_pkg::FRAME_LEN)
        else $error("checked frame with wrong count");

endmodule

bind hcho_sensor_frame_receiver_unit hcho_frx_props u_props
(
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .concentration_ug (concentration_ug),
    .bytes_collected  (bytes_collected)
);
